[sv/rhc_pkg.sv]
package rhc_pkg;

  // Default component width (red, green, blue, saturation, lightness).
  localparam int COMPONENT_BITS_DEF = 8;

  // Hue is whole degrees, 0..359.
  localparam int HUE_BITS = 9;
  localparam logic [HUE_BITS-1:0] HUE_WRAP = HUE_BITS'(360);

  // Extra numerator bits the hue path needs above a component:
  // 2*360*M + M < 1024*2^CB.
  localparam int HUE_EXTRA_BITS = 10;

endpackage

[sv/rhc_front.sv]
module rhc_front
  import rhc_pkg::*;
#(
  parameter int CB = COMPONENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [CB-1:0]                 red,
  input  logic [CB-1:0]                 green,
  input  logic [CB-1:0]                 blue,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [2*CB+1:0]               sat_rem_o,
  output logic [CB:0]                   sat_div_o,
  output logic [CB+HUE_EXTRA_BITS-1:0]  hue_rem_o,
  output logic [CB:0]                   hue_div_o,
  output logic [CB-1:0]                 light_o
);

  localparam int SNW = 2 * CB + 2;
  localparam int HNW = CB + HUE_EXTRA_BITS;
  localparam logic [CB:0] CMAX = {1'b0, {CB{1'b1}}};

  logic [CB-1:0]  mx, mn, d, den;
  logic [CB:0]    sum;
  logic [HNW-1:0] hd, hr, hg, hb, hnum;
  logic [SNW-1:0] sd;

  logic            vld_r;
  logic [SNW-1:0]  sat_rem_r, sat_rem_nxt;
  logic [CB:0]     sat_div_r, sat_div_nxt;
  logic [HNW-1:0]  hue_rem_r, hue_rem_nxt;
  logic [CB:0]     hue_div_r, hue_div_nxt;
  logic [CB-1:0]   light_r, light_nxt;

  always_comb begin
    mx  = (red > green) ? red : green;
    mx  = (mx > blue) ? mx : blue;
    mn  = (red < green) ? red : green;
    mn  = (mn < blue) ? mn : blue;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum > CMAX) ? CB'((CMAX << 1) - sum) : CB'(sum);
    light_nxt = CB'((sum + (CB+1)'(1)) >> 1);

    hd = HNW'(d);
    hr = HNW'(red);
    hg = HNW'(green);
    hb = HNW'(blue);
    // Sector numerator, 60 * (sector formula) * d, always non-negative.
    if (mx == red) begin
      if (green >= blue) begin
        hnum = (hg - hb) * HNW'(60);
      end else begin
        hnum = hd * HNW'(360) - (hb - hg) * HNW'(60);
      end
    end else if (mx == green) begin
      hnum = hd * HNW'(120) + hb * HNW'(60) - hr * HNW'(60);
    end else begin
      hnum = hd * HNW'(240) + hr * HNW'(60) - hg * HNW'(60);
    end

    // Round-half-up division num/den done as (2*num + den) / (2*den).
    sd = SNW'(d);
    if (d == '0) begin
      // Grey: force both quotients to zero.
      sat_rem_nxt = '0;
      sat_div_nxt = (CB+1)'(2);
      hue_rem_nxt = '0;
      hue_div_nxt = (CB+1)'(2);
    end else begin
      sat_rem_nxt = ((sd << CB) - sd) * SNW'(2) + SNW'(den);
      sat_div_nxt = {den, 1'b0};
      hue_rem_nxt = (hnum << 1) + hd;
      hue_div_nxt = {d, 1'b0};
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sat_rem_r <= sat_rem_nxt;
      sat_div_r <= sat_div_nxt;
      hue_rem_r <= hue_rem_nxt;
      hue_div_r <= hue_div_nxt;
      light_r   <= light_nxt;
    end
  end

  assign dn_valid  = vld_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_div_o = sat_div_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign light_o   = light_r;

endmodule

[sv/rhc_cell.sv]
module rhc_cell
  import rhc_pkg::*;
#(
  parameter int CB  = COMPONENT_BITS_DEF,
  parameter int QB  = HUE_BITS,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [2*CB+1:0]               sat_rem_i,
  input  logic [CB:0]                   sat_div_i,
  input  logic [QB-1:0]                 sat_q_i,
  input  logic [CB+HUE_EXTRA_BITS-1:0]  hue_rem_i,
  input  logic [CB:0]                   hue_div_i,
  input  logic [QB-1:0]                 hue_q_i,
  input  logic [CB-1:0]                 light_i,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [2*CB+1:0]               sat_rem_o,
  output logic [CB:0]                   sat_div_o,
  output logic [QB-1:0]                 sat_q_o,
  output logic [CB+HUE_EXTRA_BITS-1:0]  hue_rem_o,
  output logic [CB:0]                   hue_div_o,
  output logic [QB-1:0]                 hue_q_o,
  output logic [CB-1:0]                 light_o
);

  localparam int SNW = 2 * CB + 2;
  localparam int HNW = CB + HUE_EXTRA_BITS;
  localparam int SCW = SNW + QB;
  localparam int HCW = HNW + QB;

  logic [SCW-1:0] s_trial;
  logic [HCW-1:0] h_trial;
  logic           s_take, h_take;

  logic            vld_r;
  logic [SNW-1:0]  sat_rem_r, sat_rem_nxt;
  logic [CB:0]     sat_div_r;
  logic [QB-1:0]   sat_q_r, sat_q_nxt;
  logic [HNW-1:0]  hue_rem_r, hue_rem_nxt;
  logic [CB:0]     hue_div_r;
  logic [QB-1:0]   hue_q_r, hue_q_nxt;
  logic [CB-1:0]   light_r;

  // One restoring step for each divider: quotient bit IDX.
  always_comb begin
    s_trial     = SCW'(sat_div_i) << IDX;
    s_take      = SCW'(sat_rem_i) >= s_trial;
    sat_rem_nxt = s_take ? SNW'(SCW'(sat_rem_i) - s_trial) : sat_rem_i;
    sat_q_nxt   = sat_q_i | (QB'(s_take) << IDX);

    h_trial     = HCW'(hue_div_i) << IDX;
    h_take      = HCW'(hue_rem_i) >= h_trial;
    hue_rem_nxt = h_take ? HNW'(HCW'(hue_rem_i) - h_trial) : hue_rem_i;
    hue_q_nxt   = hue_q_i | (QB'(h_take) << IDX);
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sat_rem_r <= sat_rem_nxt;
      sat_div_r <= sat_div_i;
      sat_q_r   <= sat_q_nxt;
      hue_rem_r <= hue_rem_nxt;
      hue_div_r <= hue_div_i;
      hue_q_r   <= hue_q_nxt;
      light_r   <= light_i;
    end
  end

  assign dn_valid  = vld_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_div_o = sat_div_r;
  assign sat_q_o   = sat_q_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign hue_q_o   = hue_q_r;
  assign light_o   = light_r;

endmodule

[sv/rgb_to_hsl_converter.sv]
// Channel   Ports                                        Direction
// input     in_valid, in_ready, in_red/green/blue        pixel in (COMPONENT_BITS each)
// result    out_valid, out_ready, out_hue/saturation/    HSL out (hue 9 bits,
//           out_lightness                                others COMPONENT_BITS)
//
// Throughput is one pixel per clock while out_ready is high. One front stage, then
// one divider cell per quotient bit.
// Reset clears only the valid flags of the stages; payload registers are not reset.
// A stall at out_ready backs up stage by stage; empty stages keep filling, so input
// is still taken until every stage holds a pixel.
module rgb_to_hsl_converter
  import rhc_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [HUE_BITS-1:0]       out_hue,
  output logic [COMPONENT_BITS-1:0] out_saturation,
  output logic [COMPONENT_BITS-1:0] out_lightness
);

  localparam int CB  = COMPONENT_BITS;
  localparam int SNW = 2 * CB + 2;
  localparam int HNW = CB + HUE_EXTRA_BITS;
  // Quotient bits: saturation needs CB, hue needs HUE_BITS.
  localparam int QB  = (CB > HUE_BITS) ? CB : HUE_BITS;

  // Chain taps: index 0 is the front stage output, index QB the last cell.
  logic            vld   [0:QB];
  logic            rdy   [0:QB];
  logic [SNW-1:0]  s_rem [0:QB];
  logic [CB:0]     s_div [0:QB];
  logic [QB-1:0]   s_q   [0:QB];
  logic [HNW-1:0]  h_rem [0:QB];
  logic [CB:0]     h_div [0:QB];
  logic [QB-1:0]   h_q   [0:QB];
  logic [CB-1:0]   light [0:QB];

  logic [HUE_BITS-1:0] hue_raw;

  // Min/max, lightness and the two rounded-division operands.
  rhc_front #(
    .CB(CB)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .dn_valid  (vld[0]),
    .dn_ready  (rdy[0]),
    .sat_rem_o (s_rem[0]),
    .sat_div_o (s_div[0]),
    .hue_rem_o (h_rem[0]),
    .hue_div_o (h_div[0]),
    .light_o   (light[0])
  );

  assign s_q[0] = '0;
  assign h_q[0] = '0;

  // Divider cells, MSB quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_cell
    rhc_cell #(
      .CB (CB),
      .QB (QB),
      .IDX(QB - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (vld[k]),
      .up_ready  (rdy[k]),
      .sat_rem_i (s_rem[k]),
      .sat_div_i (s_div[k]),
      .sat_q_i   (s_q[k]),
      .hue_rem_i (h_rem[k]),
      .hue_div_i (h_div[k]),
      .hue_q_i   (h_q[k]),
      .light_i   (light[k]),
      .dn_valid  (vld[k+1]),
      .dn_ready  (rdy[k+1]),
      .sat_rem_o (s_rem[k+1]),
      .sat_div_o (s_div[k+1]),
      .sat_q_o   (s_q[k+1]),
      .hue_rem_o (h_rem[k+1]),
      .hue_div_o (h_div[k+1]),
      .hue_q_o   (h_q[k+1]),
      .light_o   (light[k+1])
    );
  end

  assign rdy[QB]   = out_ready;
  assign out_valid = vld[QB];

  // A hue that rounds to 360 wraps to 0.
  assign hue_raw        = h_q[QB][HUE_BITS-1:0];
  assign out_hue        = (hue_raw >= HUE_WRAP) ? (hue_raw - HUE_WRAP) : hue_raw;
  assign out_saturation = s_q[QB][CB-1:0];
  assign out_lightness  = light[QB];

endmodule

[verif/tb_rgb_to_hsl_converter.sv]
`timescale 1ns / 100ps

module tb_rgb_to_hsl_converter;
  import rhc_pkg::*;

  localparam int CB = COMPONENT_BITS_DEF;
  localparam int unsigned CMAX = (1 << CB) - 1;

  // Pipeline is max(CB, 9) + 1 deep.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PIXELS = 850;

  // Backpressure-free window, in cycles from the start of the run.
  localparam int QUIET_START = 400;
  localparam int QUIET_END = 900;
  localparam int IDLE_PCT = 35;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [CB-1:0]       saturation;
    logic [CB-1:0]       lightness;
  } hsl_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [CB-1:0] in_red = '0;
  logic [CB-1:0] in_green = '0;
  logic [CB-1:0] in_blue = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [HUE_BITS-1:0] out_hue;
  logic [CB-1:0] out_saturation;
  logic [CB-1:0] out_lightness;

  pixel_t pixel_queue[$];
  hsl_t   hsl_expected[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  logic   in_fire = 1'b0;

  rgb_to_hsl_converter #(
    .COMPONENT_BITS(CB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_lightness (out_lightness)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Round num/den to nearest, halves up.
  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Exact-integer HSL of one pixel. Grey gives hue 0 and saturation 0;
  // a hue that rounds up to 360 wraps to 0.
  function automatic hsl_t convert_pixel(pixel_t px);
    int unsigned r, g, b, mx, mn, delta, sum, den;
    longint unsigned num, hue_deg, sat;
    hsl_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    sum = mx + mn;
    hue_deg = 0;
    sat = 0;
    if (delta != 0) begin
      den = (sum > CMAX) ? (2 * CMAX - sum) : sum;
      sat = round_div(longint'(CMAX) * delta, den);
      if (mx == r) begin
        // Red sector; negative hue (green below blue) wraps by +360.
        if (g >= b) num = 60 * longint'(g - b);
        else num = 360 * longint'(delta) - 60 * longint'(b - g);
      end else if (mx == g) begin
        num = 120 * longint'(delta) + 60 * longint'(b) - 60 * longint'(r);
      end else begin
        num = 240 * longint'(delta) + 60 * longint'(r) - 60 * longint'(g);
      end
      hue_deg = round_div(num, delta);
      if (hue_deg >= 360) hue_deg -= 360;
    end
    res.hue = hue_deg[HUE_BITS-1:0];
    res.saturation = sat[CB-1:0];
    res.lightness = CB'((sum + 1) >> 1);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void add_pixel(int r, int g, int b);
    pixel_t px;
    px.red = CB'(r);
    px.green = CB'(g);
    px.blue = CB'(b);
    pixel_queue = {pixel_queue, px};
  endfunction

  // One random component: mostly uniform, sometimes pinned to an extreme.
  function automatic int pick_component();
    case ($urandom_range(3))
      0: begin
        return ($urandom_range(1) != 0) ? CMAX : 0;
      end
      default: begin
        return $urandom_range(CMAX);
      end
    endcase
  endfunction

  // Random traffic decision shared by both sides: idles ~35% of cycles,
  // except inside the quiet window where the pipe runs flat out.
  function automatic bit want_idle();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_END) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: payload and valid change on the falling edge only. A new
  // transaction is launched once the previous one was accepted.
  always @(negedge clk) begin
    pixel_t px;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pixel_queue.size() != 0 && !want_idle()) begin
          px = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_red <= px.red;
          in_green <= px.green;
          in_blue <= px.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !want_idle();
    end
  end

  // Monitor: accepted input transactions feed the predictor; accepted results
  // are checked against the oldest prediction.
  always @(posedge clk) begin
    pixel_t px;
    hsl_t want;
    in_fire <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      px.red = in_red;
      px.green = in_green;
      px.blue = in_blue;
      hsl_expected = {hsl_expected, convert_pixel(px)};
    end
    if (rst_n && out_valid && out_ready) begin
      if (hsl_expected.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = hsl_expected.pop_front();
        if (out_hue !== want.hue) report_mismatch("hue", out_hue, want.hue);
        if (out_saturation !== want.saturation)
          report_mismatch("saturation", out_saturation, want.saturation);
        if (out_lightness !== want.lightness)
          report_mismatch("lightness", out_lightness, want.lightness);
      end
    end
  end

  initial begin
    int r, g, b, base;

    // Directed: black, white, primaries, secondaries, greys.
    add_pixel(0, 0, 0);
    add_pixel(CMAX, CMAX, CMAX);
    add_pixel(CMAX, 0, 0);
    add_pixel(0, CMAX, 0);
    add_pixel(0, 0, CMAX);
    add_pixel(CMAX, CMAX, 0);
    add_pixel(0, CMAX, CMAX);
    add_pixel(CMAX, 0, CMAX);
    add_pixel(128, 128, 128);
    add_pixel(127, 127, 127);
    // Red max, green below blue: negative hue wraps; this one rounds to 360 -> 0.
    add_pixel(CMAX, 0, 1);
    add_pixel(CMAX, 0, 128);
    // Two-way ties for the maximum.
    add_pixel(200, 200, 50);
    add_pixel(50, 200, 200);
    add_pixel(200, 50, 200);
    // Smallest nonzero deltas, dark and bright.
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    add_pixel(CMAX - 1, CMAX, CMAX);
    add_pixel(CMAX, CMAX - 1, CMAX - 1);
    // Half-way roundings in lightness.
    add_pixel(128, 127, 128);
    add_pixel(1, 1, 0);
    add_pixel(170, 85, 0);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          // Near grey: tiny delta around a random level.
          base = $urandom_range(CMAX);
          r = base + $urandom_range(2) - 1;
          g = base + $urandom_range(2) - 1;
          b = base + $urandom_range(2) - 1;
          r = (r < 0) ? 0 : (r > CMAX) ? CMAX : r;
          g = (g < 0) ? 0 : (g > CMAX) ? CMAX : g;
          b = (b < 0) ? 0 : (b > CMAX) ? CMAX : b;
        end
        2: begin
          // Tie between two components.
          base = $urandom_range(CMAX);
          r = base;
          g = base;
          b = $urandom_range(CMAX);
          case ($urandom_range(2))
            0: begin
              g = b;
              b = base;
            end
            1: begin
              r = b;
              b = base;
            end
            default: ;
          endcase
        end
        3, 4: begin
          r = pick_component();
          g = pick_component();
          b = pick_component();
        end
        default: begin
          r = $urandom_range(CMAX);
          g = $urandom_range(CMAX);
          b = $urandom_range(CMAX);
        end
      endcase
      add_pixel(r, g, b);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to go in and every result to come out.
    while (pixel_queue.size() != 0 || in_valid || hsl_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hsl_expected.size() != 0)
      report_mismatch("missing result transactions", 0, hsl_expected.size());

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
